// File: src/cssg_pkg.sv
// Shared types and constants for the column scan glyph segmenter.
package cssg_pkg;

   localparam int PIX_W        = 8;
   localparam int POS_W        = 10;
   localparam int DEF_MAX_COLS = 1024;
   localparam int DEF_MAX_ROWS = 1024;
   localparam logic [PIX_W-1:0] THRESH_RESET = 8'd128;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             column_end;
      logic             frame_start;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0] left_col;
      logic [POS_W-1:0] right_col;
      logic [POS_W-1:0] top_row;
      logic [POS_W-1:0] bottom_row;
      logic             bottom_found;
   } rsp_type;

   // Input register contents handed to the tracking stage.
   typedef struct packed {
      logic    valid;
      req_type item;
   } stage_type;

endpackage

// File: src/column_scan_glyph_segmenter_unit.sv
// Top level of the column scan glyph segmenter.
//
//   channel | ports                         | direction | carries
//   req     | req_valid req_stall req_data   | in        | pixel, column_end, frame_start
//   rsp     | rsp_valid rsp_stall rsp_data   | out       | one box per closed shape
//   csr     | csr_valid csr_ready csr_data   | in        | dark_threshold
//
// One pixel a cycle sustained while the result is not stalled. A pixel is held in
// the input register and its box, if any, is then written to the result register.
// Reset clears the tracking flags and counters, the valid flags of both registers
// and sets the threshold to 128. A stalled result holds the tracking stage; the input
// register then fills and req_stall rises. csr_ready is always high.
module column_scan_glyph_segmenter_unit #(
   parameter int MAX_COLS = cssg_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = cssg_pkg::DEF_MAX_ROWS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  cssg_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output cssg_pkg::rsp_type           rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [cssg_pkg::PIX_W-1:0]  csr_data
);

   logic [cssg_pkg::PIX_W-1:0] thresh_ff, thresh_in;
   cssg_pkg::stage_type        stage;
   logic                       proc_ready;

   assign csr_ready = 1'b1;
   assign thresh_in = (csr_valid && csr_ready) ? csr_data : thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= cssg_pkg::THRESH_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   cssg_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .proc_ready (proc_ready),
      .stage      (stage)
   );

   cssg_track #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage),
      .threshold  (thresh_ff),
      .proc_ready (proc_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// File: src/cssg_in_stage.sv
// Input register: holds one pixel transfer until the tracking stage takes it.
module cssg_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  cssg_pkg::req_type   req_data,
   input  logic                proc_ready,
   output cssg_pkg::stage_type stage
);

   logic              valid_ff, valid_in;
   cssg_pkg::req_type item_ff, item_in;
   logic              advance;
   logic              accept;

   assign advance   = valid_ff && proc_ready;
   assign req_stall = valid_ff && !proc_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in = 1'b1;
         item_in  = req_data;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

// File: src/cssg_track.sv
// Shape tracking state, box emission and the result register.
module cssg_track #(
   parameter int MAX_COLS = cssg_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = cssg_pkg::DEF_MAX_ROWS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cssg_pkg::stage_type           stage,
   input  logic [cssg_pkg::PIX_W-1:0]    threshold,
   output logic                          proc_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output cssg_pkg::rsp_type             rsp_data
);

   localparam int CW  = $clog2(MAX_COLS);
   localparam int RW  = $clog2(MAX_ROWS);
   localparam int CEW = (CW > cssg_pkg::POS_W) ? CW : cssg_pkg::POS_W;
   localparam int REW = (RW > cssg_pkg::POS_W) ? RW : cssg_pkg::POS_W;
   localparam logic [CW-1:0] COL_LAST = CW'(MAX_COLS - 1);
   localparam logic [RW-1:0] ROW_LAST = RW'(MAX_ROWS - 1);

   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic          ink_ff, ink_in;
   logic          prev_ff, prev_in;
   logic          left_v_ff, left_v_in;
   logic          top_v_ff, top_v_in;
   logic          bot_v_ff, bot_v_in;
   logic [CW-1:0] left_ff, left_in;
   logic [RW-1:0] top_ff, top_in;
   logic [RW-1:0] bot_ff, bot_in;
   logic          rsp_valid_ff, rsp_valid_in;
   cssg_pkg::rsp_type rsp_ff, rsp_in;

   logic          go;
   logic          dark;
   logic          emit;
   logic [RW-1:0] row_cur;
   logic [CW-1:0] col_cur;
   logic          ink_cur, prev_cur, left_v_cur, top_v_cur, bot_v_cur;
   logic [CEW-1:0] left_ext, right_ext;
   logic [REW-1:0] top_ext, bot_ext;

   assign proc_ready = !(rsp_valid_ff && rsp_stall);
   assign go         = stage.valid && proc_ready;
   assign dark       = stage.item.pixel < threshold;

   always_comb begin
      // frame start clears tracking before the pixel is looked at
      row_cur    = stage.item.frame_start ? '0   : row_ff;
      col_cur    = stage.item.frame_start ? '0   : col_ff;
      ink_cur    = stage.item.frame_start ? 1'b0 : ink_ff;
      prev_cur   = stage.item.frame_start ? 1'b0 : prev_ff;
      left_v_cur = stage.item.frame_start ? 1'b0 : left_v_ff;
      top_v_cur  = stage.item.frame_start ? 1'b0 : top_v_ff;
      bot_v_cur  = stage.item.frame_start ? 1'b0 : bot_v_ff;

      row_in    = row_cur;
      col_in    = col_cur;
      ink_in    = ink_cur;
      left_v_in = left_v_cur;
      top_v_in  = top_v_cur;
      bot_v_in  = bot_v_cur;
      left_in   = left_ff;
      top_in    = top_ff;
      bot_in    = bot_ff;
      emit      = 1'b0;

      if (dark) begin
         if (!top_v_cur || row_cur < top_ff) begin
            top_in   = row_cur;
            top_v_in = 1'b1;
         end
         ink_in = 1'b1;
      end else if (row_cur != '0 && prev_cur && (!bot_v_cur || row_cur > bot_ff)) begin
         bot_in   = row_cur;
         bot_v_in = 1'b1;
      end
      prev_in = dark;

      if (stage.item.column_end) begin
         if (ink_in) begin
            if (!left_v_cur) begin
               left_in   = col_cur;
               left_v_in = 1'b1;
            end
         end else if (left_v_cur) begin
            emit      = 1'b1;
            left_v_in = 1'b0;
            top_v_in  = 1'b0;
            bot_v_in  = 1'b0;
         end
         if (col_cur < COL_LAST) begin
            col_in = col_cur + 1'b1;
         end
         row_in  = '0;
         ink_in  = 1'b0;
         prev_in = 1'b0;
      end else if (row_cur < ROW_LAST) begin
         row_in = row_cur + 1'b1;
      end
   end

   // box fields, low bits of the positions
   assign left_ext  = CEW'(left_ff);
   assign right_ext = CEW'(col_cur);
   assign top_ext   = REW'(top_ff);
   assign bot_ext   = REW'(bot_ff);

   always_comb begin
      rsp_in              = rsp_ff;
      rsp_valid_in        = rsp_valid_ff;
      if (go) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_in.left_col     = left_ext[cssg_pkg::POS_W-1:0];
            rsp_in.right_col    = right_ext[cssg_pkg::POS_W-1:0];
            rsp_in.top_row      = top_v_cur ? top_ext[cssg_pkg::POS_W-1:0] : '0;
            rsp_in.bottom_row   = bot_v_cur ? bot_ext[cssg_pkg::POS_W-1:0] : '0;
            rsp_in.bottom_found = bot_v_cur;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         ink_ff       <= 1'b0;
         prev_ff      <= 1'b0;
         left_v_ff    <= 1'b0;
         top_v_ff     <= 1'b0;
         bot_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (go) begin
            row_ff    <= row_in;
            col_ff    <= col_in;
            ink_ff    <= ink_in;
            prev_ff   <= prev_in;
            left_v_ff <= left_v_in;
            top_v_ff  <= top_v_in;
            bot_v_ff  <= bot_v_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (go) begin
         left_ff <= left_in;
         top_ff  <= top_in;
         bot_ff  <= bot_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
